FILE: rtl/keyed_table_with_set_all_defines.svh
// Assertion macros shared by the keyed table RTL.
// Depends on nothing; included by the top level only.
`ifndef KEYED_TABLE_WITH_SET_ALL_DEFINES_SVH
`define KEYED_TABLE_WITH_SET_ALL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KTSA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KTSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ktsa_pkg.sv
// Shared types and constants for the keyed table with set-all.
// Used by the controller, the datapath and the top level; depends on nothing.
package ktsa_pkg;

	localparam int ENTRIES = 64;
	localparam int STAMP_BITS = 48;
	localparam int WORD_W = 32;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int RAM_W = 2 * WORD_W + STAMP_BITS;

	localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

	localparam logic [1:0] ACT_PUT = 2'd0;
	localparam logic [1:0] ACT_GET = 2'd1;
	localparam logic [1:0] ACT_SET_ALL = 2'd2;
	localparam logic [1:0] ACT_NOP = 2'd3;

	typedef enum logic [1:0] {
		ST_STORED = 2'd0,
		ST_HIT = 2'd1,
		ST_MISS = 2'd2,
		ST_FULL = 2'd3
	} ktsa_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DISPATCH,
		S_LOOK,
		S_CMP
	} ktsa_state_t;

	typedef struct packed {
		logic [1:0] action;
		logic signed [WORD_W-1:0] item_key;
		logic signed [WORD_W-1:0] data_value;
	} ktsa_item_t;

	typedef struct packed {
		ktsa_status_t status;
		logic signed [WORD_W-1:0] result_value;
	} ktsa_result_t;

	typedef struct packed {
		logic load;
		logic set_all;
		logic idx_next;
		logic wr_en;
		logic wr_new;
		logic resp;
		ktsa_status_t resp_status;
	} ktsa_cmd_t;

	typedef struct packed {
		logic match;
		logic last;
		logic empty;
		logic full;
		logic [1:0] act;
	} ktsa_stat_t;

endpackage

FILE: rtl/ktsa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module ktsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/ktsa_dp.sv
// Datapath of the keyed table: entry RAM, fill count, stamps and result register.
// Depends on ktsa_pkg and ktsa_ram.
module ktsa_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ktsa_pkg::ktsa_item_t  item,
	input  ktsa_pkg::ktsa_cmd_t   cmd,
	output ktsa_pkg::ktsa_stat_t  stat,
	output logic                  done,
	output ktsa_pkg::ktsa_result_t result
);
	import ktsa_pkg::*;

	ktsa_item_t item_q;
	ktsa_result_t result_q;
	logic done_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic [STAMP_BITS-1:0] all_stamp_q;
	logic [WORD_W-1:0] all_value_q;

	logic [RAM_W-1:0] rd_word;
	logic [RAM_W-1:0] wr_word;
	logic [IDX_W-1:0] wr_addr;
	logic [WORD_W-1:0] rd_key;
	logic [WORD_W-1:0] rd_value;
	logic [STAMP_BITS-1:0] rd_stamp;
	logic [WORD_W-1:0] hit_value;
	logic take_stamp;

	assign rd_key = rd_word[RAM_W-1 -: WORD_W];
	assign rd_value = rd_word[STAMP_BITS +: WORD_W];
	assign rd_stamp = rd_word[STAMP_BITS-1:0];
	assign wr_word = {item_q.item_key, item_q.data_value, stamp_q};
	assign wr_addr = cmd.wr_new ? cnt_q[IDX_W-1:0] : idx_q;
	assign take_stamp = cmd.wr_en | cmd.set_all;
	assign hit_value = (rd_stamp < all_stamp_q) ? all_value_q : rd_value;

	ktsa_ram #(
		.WIDTH(RAM_W),
		.DEPTH(ENTRIES)
	) u_entry_ram (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(wr_addr),
		.wdata(wr_word),
		.raddr(idx_q),
		.rdata(rd_word)
	);

	always_comb begin
		stat.match = (rd_key == item_q.item_key);
		stat.last = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);
		stat.empty = (cnt_q == '0);
		stat.full = (cnt_q == CNT_W'(ENTRIES));
		stat.act = item_q.action;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.resp) begin
			result_q.status <= cmd.resp_status;
			unique case (cmd.resp_status)
				ST_HIT: result_q.result_value <= hit_value;
				ST_MISS: result_q.result_value <= '1;
				ST_STORED, ST_FULL: result_q.result_value <= '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			idx_q <= '0;
			cnt_q <= '0;
			stamp_q <= '0;
			all_stamp_q <= '0;
			all_value_q <= '0;
		end else begin
			done_q <= cmd.resp;
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.idx_next) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.wr_en && cmd.wr_new) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (take_stamp && stamp_q != STAMP_MAX) begin
				stamp_q <= stamp_q + 1'b1;
			end
			if (cmd.set_all) begin
				all_stamp_q <= stamp_q;
				all_value_q <= item_q.data_value;
			end
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

FILE: rtl/ktsa_ctrl.sv
// Controller of the keyed table: sequences the key scan and issues datapath commands.
// Depends on ktsa_pkg.
module ktsa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  ktsa_pkg::ktsa_stat_t stat,
	output ktsa_pkg::ktsa_cmd_t  cmd,
	output logic                 busy
);
	import ktsa_pkg::*;

	ktsa_state_t state_q;
	ktsa_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.resp_status = ST_STORED;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (stat.act)
					ACT_PUT, ACT_GET: begin
						if (!stat.empty) begin
							state_d = S_LOOK;
						end else begin
							cmd.resp = 1'b1;
							state_d = S_IDLE;
							if (stat.act == ACT_GET) begin
								cmd.resp_status = ST_MISS;
							end else begin
								cmd.wr_en = 1'b1;
								cmd.wr_new = 1'b1;
							end
						end
					end
					ACT_SET_ALL: begin
						cmd.set_all = 1'b1;
						cmd.resp = 1'b1;
						state_d = S_IDLE;
					end
					ACT_NOP: begin
						cmd.resp = 1'b1;
						state_d = S_IDLE;
					end
				endcase
			end
			S_LOOK: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				priority if (stat.match) begin
					cmd.resp = 1'b1;
					state_d = S_IDLE;
					if (stat.act == ACT_GET) begin
						cmd.resp_status = ST_HIT;
					end else begin
						cmd.wr_en = 1'b1;
					end
				end else if (stat.last) begin
					cmd.resp = 1'b1;
					state_d = S_IDLE;
					if (stat.act == ACT_GET) begin
						cmd.resp_status = ST_MISS;
					end else if (stat.full) begin
						cmd.resp_status = ST_FULL;
					end else begin
						cmd.wr_en = 1'b1;
						cmd.wr_new = 1'b1;
					end
				end else begin
					cmd.idx_next = 1'b1;
					state_d = S_LOOK;
				end
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

FILE: rtl/keyed_table_with_set_all.sv
// Top level of the keyed table with constant-time set-all.
// Depends on ktsa_pkg, ktsa_ctrl, ktsa_dp and the assertion macro header.
//
// An item is accepted at a clock edge where start is high and busy is low.
// Each item is a put, a get, a set-all or an unused action and yields exactly
// one result beat, shown on result for one cycle with done high; the receiver
// cannot stall it. A set-all, an unused action or any item on an empty table
// is answered from the dispatch state, with done registered after it. A put or
// get scans the stored keys in order, each entry taking a look state and a
// compare state through the registered read port of the entry RAM; at most
// ENTRIES entries are examined. This scan over the single RAM read port sets
// the time to done. Busy is low again in the cycle that shows done, so the
// next item may be accepted there. Reset clears the table, the stamp counter
// and the set-all value at once; no clearing pass is needed, since entries
// fill from slot zero upward and a fill count marks which are live.
`include "keyed_table_with_set_all_defines.svh"

module keyed_table_with_set_all (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  ktsa_pkg::ktsa_item_t   item,
	output logic                   busy,
	output logic                   done,
	output ktsa_pkg::ktsa_result_t result
);
	import ktsa_pkg::*;

	ktsa_cmd_t cmd;
	ktsa_stat_t stat;

	ktsa_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	ktsa_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.cmd   (cmd),
		.stat  (stat),
		.done  (done),
		.result(result)
	);

	`KTSA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted beat did not raise busy")
	`KTSA_ASSERT_NEXT(a_resp_done, clk, arst_n, cmd.resp, done, "response did not produce a done strobe")
	`KTSA_ASSERT_SAME(a_full_status, clk, arst_n, done && result.status == ST_FULL, stat.full, "refused put while the table is not full")
	`KTSA_ASSERT_SAME(a_write_room, clk, arst_n, cmd.wr_en && cmd.wr_new, !stat.full, "new entry written into a full table")

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for keyed_table_with_set_all: puts, gets and set-alls
// are checked against a predictor kept in step with every accepted beat.
// Depends on ktsa_pkg and the keyed_table_with_set_all RTL.
module testbench;
	import ktsa_pkg::*;

	localparam int POOL_KEYS = 40;
	localparam int LONG_GAP = 2 * ENTRIES + 8;
	localparam int QUIET_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic start;
	ktsa_item_t item;
	logic busy;
	logic done;
	ktsa_result_t result;

	logic table_used [ENTRIES];
	logic [WORD_W-1:0] table_key [ENTRIES];
	logic [WORD_W-1:0] table_value [ENTRIES];
	logic [STAMP_BITS-1:0] table_stamp [ENTRIES];
	logic [STAMP_BITS-1:0] stamp_count;
	logic [STAMP_BITS-1:0] set_all_stamp;
	logic [WORD_W-1:0] set_all_value;
	int fill_count;

	ktsa_result_t pending_results [$];
	logic [WORD_W-1:0] key_pool [POOL_KEYS];
	bit gaps_on;
	int error_count;
	int quiet_cycles;

	keyed_table_with_set_all uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [STAMP_BITS-1:0] next_stamp();
		logic [STAMP_BITS-1:0] s;
		s = stamp_count;
		if (stamp_count != STAMP_MAX)
			stamp_count = stamp_count + 1'b1;
		return s;
	endfunction

	function automatic ktsa_result_t predict_result(ktsa_item_t it);
		ktsa_result_t r;
		int slot;
		logic [WORD_W-1:0] key;
		key = it.item_key;
		r.status = ST_STORED;
		r.result_value = '0;
		slot = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (slot < 0 && table_used[i] && table_key[i] == key)
				slot = i;
		case (it.action)
			ACT_PUT: begin
				if (slot < 0) begin
					for (int i = 0; i < ENTRIES; i++)
						if (slot < 0 && !table_used[i])
							slot = i;
					if (slot >= 0) begin
						table_used[slot] = 1'b1;
						table_key[slot] = key;
						fill_count++;
					end
				end
				if (slot < 0) begin
					r.status = ST_FULL;
				end else begin
					table_value[slot] = it.data_value;
					table_stamp[slot] = next_stamp();
				end
			end
			ACT_GET: begin
				if (slot < 0) begin
					r.status = ST_MISS;
					r.result_value = '1;
				end else begin
					r.status = ST_HIT;
					r.result_value = (table_stamp[slot] < set_all_stamp) ?
						set_all_value : table_value[slot];
				end
			end
			ACT_SET_ALL: begin
				set_all_value = it.data_value;
				set_all_stamp = next_stamp();
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic ktsa_item_t make_item(logic [1:0] act, logic [WORD_W-1:0] key,
			logic [WORD_W-1:0] val);
		ktsa_item_t it;
		it.action = act;
		it.item_key = key;
		it.data_value = val;
		return it;
	endfunction

	function automatic logic [1:0] random_action();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return ACT_PUT;
		else if (r < 85)
			return ACT_GET;
		else if (r < 95)
			return ACT_SET_ALL;
		else
			return ACT_NOP;
	endfunction

	task automatic send_item(input ktsa_item_t it);
		int gap;
		if (gaps_on) begin
			gap = 0;
			if ($urandom_range(99) < 3)
				gap = $urandom_range(LONG_GAP, 1);
			while ($urandom_range(99) < 20)
				gap++;
			if (gap > 0) begin
				start <= 1'b0;
				while (busy)
					@(negedge clk);
				repeat (gap)
					@(negedge clk);
			end
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(predict_result(it));
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_empty_table();
		send_item(make_item(ACT_GET, 32'h0000_0000, 32'h0000_0000));
		send_item(make_item(ACT_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_item(make_item(ACT_SET_ALL, 32'h0000_0000, 32'h0000_0000));
	endtask

	task automatic test_put_get();
		send_item(make_item(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF));
		send_item(make_item(ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF));
		send_item(make_item(ACT_GET, 32'h0000_0000, 32'h0000_0000));
		send_item(make_item(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000));
		send_item(make_item(ACT_PUT, 32'hFFFF_FFFF, 32'h0000_0000));
		send_item(make_item(ACT_PUT, 32'h0000_0000, 32'hFFFF_FFFF));
		send_item(make_item(ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000));
		send_item(make_item(ACT_GET, 32'hFFFF_FFFE, 32'h0000_0000));
		send_item(make_item(ACT_PUT, 32'hAAAA_AAAA, 32'h5555_5555));
		send_item(make_item(ACT_GET, 32'hAAAA_AAAA, 32'h0000_0000));
	endtask

	task automatic test_set_all();
		send_item(make_item(ACT_SET_ALL, 32'hFFFF_FFFF, 32'h1234_5678));
		send_item(make_item(ACT_GET, 32'h0000_0000, 32'h0000_0000));
		send_item(make_item(ACT_PUT, 32'h0000_0000, 32'h5555_5555));
		send_item(make_item(ACT_GET, 32'h0000_0000, 32'h0000_0000));
		send_item(make_item(ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000));
		send_item(make_item(ACT_NOP, 32'h5555_5555, 32'hAAAA_AAAA));
		send_item(make_item(ACT_SET_ALL, 32'h0000_0000, 32'h8000_0000));
		send_item(make_item(ACT_GET, 32'h8000_0000, 32'h0000_0000));
		send_item(make_item(ACT_SET_ALL, 32'h8000_0000, 32'h7FFF_FFFF));
		send_item(make_item(ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000));
	endtask

	task automatic test_random_mix(input int count);
		logic [1:0] act;
		logic [WORD_W-1:0] key;
		for (int n = 0; n < count; n++) begin
			gaps_on = (n >= 150);
			if (n == count / 2)
				wait_for_results();
			act = random_action();
			if (act == ACT_GET && $urandom_range(4) == 0)
				key = $urandom;
			else if (act == ACT_PUT || act == ACT_GET)
				key = key_pool[$urandom_range(POOL_KEYS - 1)];
			else
				key = $urandom;
			send_item(make_item(act, key, $urandom));
		end
	endtask

	task automatic test_table_full();
		logic [WORD_W-1:0] key;
		while (fill_count < ENTRIES)
			send_item(make_item(ACT_PUT, $urandom, $urandom));
		key = $urandom;
		send_item(make_item(ACT_PUT, key, $urandom));
		send_item(make_item(ACT_GET, key, $urandom));
		send_item(make_item(ACT_PUT, $urandom, $urandom));
		send_item(make_item(ACT_PUT, table_key[0], $urandom));
		send_item(make_item(ACT_GET, table_key[0], $urandom));
		send_item(make_item(ACT_SET_ALL, $urandom, $urandom));
		send_item(make_item(ACT_GET, table_key[ENTRIES - 1], $urandom));
		send_item(make_item(ACT_PUT, table_key[ENTRIES - 1], $urandom));
		send_item(make_item(ACT_GET, table_key[ENTRIES - 1], $urandom));
	endtask

	task automatic test_random_on_full(input int count);
		logic [1:0] act;
		logic [WORD_W-1:0] key;
		gaps_on = 1'b1;
		for (int n = 0; n < count; n++) begin
			act = random_action();
			if ($urandom_range(9) < 7)
				key = table_key[$urandom_range(ENTRIES - 1)];
			else
				key = $urandom;
			send_item(make_item(act, key, $urandom));
		end
	endtask

	always @(posedge clk) begin
		ktsa_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat status=%0d value=%h",
					$time, result.status, result.result_value);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.status !== want.status ||
						result.result_value !== want.result_value) begin
					$display("%0t: expected status=%0d value=%h, actual status=%0d value=%h",
						$time, want.status, want.result_value,
						result.status, result.result_value);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		error_count = 0;
		gaps_on = 1'b1;
		fill_count = 0;
		stamp_count = '0;
		set_all_stamp = '0;
		set_all_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			table_used[i] = 1'b0;
			table_key[i] = '0;
			table_value[i] = '0;
			table_stamp[i] = '0;
		end
		for (int i = 0; i < POOL_KEYS; i++)
			key_pool[i] = $urandom;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_table();
		test_put_get();
		test_set_all();
		test_random_mix(500);
		test_table_full();
		test_random_on_full(550);

		wait_for_results();
		repeat (LONG_GAP) @(posedge clk);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/ktsa_pkg.sv
rtl/ktsa_ram.sv
rtl/ktsa_dp.sv
rtl/ktsa_ctrl.sv
rtl/keyed_table_with_set_all.sv
dv/testbench.sv
